// File: rtl/tbgr_pkg.sv
package tbgr_pkg;

   localparam int TEXT_LEN_DEF   = 32;
   localparam int GLYPH_W_DEF    = 6;
   localparam int GLYPH_H_DEF    = 8;
   localparam int FIRST_CODE_DEF = 32;
   localparam int LAST_CODE_DEF  = 126;

   localparam int GLYPH_BYTES = 5;
   localparam logic [7:0] FALLBACK_CODE = 8'd63;

   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_CNT_W = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_W    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_H    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR = 3'd5;

   localparam logic [15:0] FG_COLOR_RESET = 16'hFFFF;
   localparam logic [15:0] BG_COLOR_RESET = 16'h0000;

   localparam logic [1:0] FUNC_TEXT  = 2'd0;
   localparam logic [1:0] FUNC_FONT  = 2'd1;
   localparam logic [1:0] FUNC_PIXEL = 2'd2;

   typedef struct packed {
      logic [1:0] func;
      logic [8:0] index;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [15:0] color;
      logic        row_end;
      logic        box_end;
   } rsp_type;

endpackage

// File: rtl/tbgr_text_mem.sv
module tbgr_text_mem import tbgr_pkg::*; #(
   parameter int DEPTH = TEXT_LEN_DEF,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0]       mem_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [7:0]       rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? mem_ff[rd_addr] : 8'd0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tbgr_font_mem.sv
module tbgr_font_mem import tbgr_pkg::*; #(
   parameter int DEPTH = (LAST_CODE_DEF - FIRST_CODE_DEF + 1) * GLYPH_BYTES,
   parameter int AW    = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tbgr_out_fifo.sv
module tbgr_out_fifo import tbgr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_type              push_item,
   output logic                 out_valid,
   input  logic                 out_stall,
   output rsp_type              out_item,
   output logic [OUT_CNT_W-1:0] level
);

   rsp_type              entry_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff;
   logic [OUT_PTR_W-1:0] rd_ptr_ff;
   logic [OUT_CNT_W-1:0] count_ff;
   logic [OUT_CNT_W-1:0] count_in;
   logic                 pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && !out_stall;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + OUT_CNT_W'(1);
         2'b01:   count_in = count_ff - OUT_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign out_item = entry_ff[rd_ptr_ff];
   assign level    = count_ff;

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != OUT_CNT_W'(OUT_DEPTH)))
      else $error("Item pushed into a full result queue.");
`endif

endmodule

// File: rtl/text_box_glyph_rasterizer.sv
// Channel | Ports                              | Moves
// req     | req_valid, req_stall, req_item     | text write, font write or pixel tick
// rsp     | rsp_valid, rsp_stall, rsp_item     | one pixel: colour, row end, box end
// csr     | csr_valid, csr_ready, csr_index,   | one register write, always ready
//         | csr_data                           |
//
// One item is taken per clock while req_stall is low; a pixel's text memory read is at the taking edge,
// and its result then passes the font memory read and the result queue write before it is valid.
// Reset clears the registers, counters and the text valid bits at once; no clearing pass.
// A four-entry result queue with credit counting parts the sides: req_stall rises only
// when the queue and the two memory stages together hold four pixels.
module text_box_glyph_rasterizer import tbgr_pkg::*; #(
   parameter int TEXT_LEN   = TEXT_LEN_DEF,
   parameter int GLYPH_W    = GLYPH_W_DEF,
   parameter int GLYPH_H    = GLYPH_H_DEF,
   parameter int FIRST_CODE = FIRST_CODE_DEF,
   parameter int LAST_CODE  = LAST_CODE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int FONT_DEPTH = (LAST_CODE - FIRST_CODE + 1) * GLYPH_BYTES;
   localparam int FONT_AW    = $clog2(FONT_DEPTH);
   localparam int TADDR_W    = (TEXT_LEN > 1) ? $clog2(TEXT_LEN) : 1;
   localparam int CPOS_W     = $clog2(TEXT_LEN + 1);
   localparam int GCOL_W     = $clog2(GLYPH_W);

   logic [7:0]  box_w_ff, box_h_ff, text_x_ff, text_y_ff;
   logic [15:0] fg_color_ff, bg_color_ff;

   logic [7:0]        row_ff, row_in;
   logic [7:0]        col_ff, col_in;
   logic [GCOL_W-1:0] gcol_ff, gcol_in;
   logic [CPOS_W-1:0] cpos_ff, cpos_in;

   logic       accept, is_pixel, in_text, last_col, last_row, pos_ok;
   logic [7:0] gy;

   logic              s1_valid_ff, s1_in_text_ff, s1_pos_ok_ff, s1_last_col_ff, s1_box_end_ff;
   logic [GCOL_W-1:0] s1_gcol_ff;
   logic [2:0]        s1_gy_ff;

   logic              ended_ff, ended_in, ended_now, fg_cand;
   logic [7:0]        code, mcode, glyph_off;
   logic [10:0]       font_addr_full;

   logic       s2_valid_ff, s2_fg_cand_ff, s2_last_col_ff, s2_box_end_ff;
   logic [2:0] s2_gy_ff;

   logic [7:0]           text_rd_data, font_rd_data;
   logic [OUT_CNT_W-1:0] fifo_level;
   rsp_type              push_item;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_w_ff    <= 8'd0;
         box_h_ff    <= 8'd0;
         text_x_ff   <= 8'd0;
         text_y_ff   <= 8'd0;
         fg_color_ff <= FG_COLOR_RESET;
         bg_color_ff <= BG_COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOX_W:    box_w_ff    <= csr_data[7:0];
            CSR_BOX_H:    box_h_ff    <= csr_data[7:0];
            CSR_TEXT_X:   text_x_ff   <= csr_data[7:0];
            CSR_TEXT_Y:   text_y_ff   <= csr_data[7:0];
            CSR_FG_COLOR: fg_color_ff <= csr_data;
            CSR_BG_COLOR: bg_color_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Credit check against the result queue.
   assign req_stall = (int'(fifo_level) + int'(s1_valid_ff) + int'(s2_valid_ff)) >= OUT_DEPTH;
   assign accept    = req_valid && !req_stall;
   assign is_pixel  = accept && (req_item.func == FUNC_PIXEL)
                      && (box_w_ff != 8'd0) && (box_h_ff != 8'd0);

   // Raster counters.
   assign gy       = row_ff - text_y_ff;
   assign in_text  = (gy < 8'(GLYPH_H)) && (col_ff >= text_x_ff);
   assign last_col = col_ff >= (box_w_ff - 8'd1);
   assign last_row = row_ff >= (box_h_ff - 8'd1);
   assign pos_ok   = cpos_ff < CPOS_W'(TEXT_LEN);

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      gcol_in = gcol_ff;
      cpos_in = cpos_ff;
      if (is_pixel) begin
         if (last_col) begin
            col_in  = 8'd0;
            gcol_in = '0;
            cpos_in = '0;
            row_in  = last_row ? 8'd0 : row_ff + 8'd1;
         end else begin
            col_in = col_ff + 8'd1;
            if (in_text) begin
               if (gcol_ff == GCOL_W'(GLYPH_W - 1)) begin
                  gcol_in = '0;
                  if (pos_ok) begin
                     cpos_in = cpos_ff + CPOS_W'(1);
                  end
               end else begin
                  gcol_in = gcol_ff + GCOL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= 8'd0;
         col_ff  <= 8'd0;
         gcol_ff <= '0;
         cpos_ff <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         gcol_ff <= gcol_in;
         cpos_ff <= cpos_in;
      end
   end

   tbgr_text_mem #(
      .DEPTH (TEXT_LEN),
      .AW    (TADDR_W)
   ) u_text_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && (req_item.func == FUNC_TEXT) && (int'(req_item.index) < TEXT_LEN)),
      .wr_addr (TADDR_W'(req_item.index)),
      .wr_data (req_item.data),
      .rd_en   (is_pixel && pos_ok),
      .rd_addr (TADDR_W'(cpos_ff)),
      .rd_data (text_rd_data)
   );

   // Stage one: character code is back from the text memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= is_pixel;
      end
   end

   always_ff @(posedge clock) begin
      s1_in_text_ff  <= in_text;
      s1_pos_ok_ff   <= pos_ok;
      s1_last_col_ff <= last_col;
      s1_box_end_ff  <= last_col && last_row;
      s1_gcol_ff     <= gcol_ff;
      s1_gy_ff       <= gy[2:0];
   end

   assign code      = text_rd_data;
   assign ended_now = s1_in_text_ff && (ended_ff || !s1_pos_ok_ff || (code == 8'd0));
   assign mcode     = ((code < 8'(FIRST_CODE)) || (code > 8'(LAST_CODE))) ? FALLBACK_CODE : code;
   assign glyph_off = mcode - 8'(FIRST_CODE);
   assign font_addr_full = ({3'b000, glyph_off} << 2) + {3'b000, glyph_off} + 11'(s1_gcol_ff);
   assign fg_cand   = s1_in_text_ff && !ended_now && (s1_gcol_ff < GCOL_W'(GLYPH_BYTES));

   always_comb begin
      ended_in = ended_ff;
      if (s1_valid_ff) begin
         if (s1_last_col_ff) begin
            ended_in = 1'b0;
         end else if (ended_now) begin
            ended_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ended_ff <= 1'b0;
      end else begin
         ended_ff <= ended_in;
      end
   end

   tbgr_font_mem #(
      .DEPTH (FONT_DEPTH),
      .AW    (FONT_AW)
   ) u_font_mem (
      .clock   (clock),
      .wr_en   (accept && (req_item.func == FUNC_FONT) && (int'(req_item.index) < FONT_DEPTH)),
      .wr_addr (FONT_AW'(req_item.index)),
      .wr_data (req_item.data),
      .rd_en   (s1_valid_ff && fg_cand),
      .rd_addr (FONT_AW'(font_addr_full)),
      .rd_data (font_rd_data)
   );

   // Stage two: glyph column byte is back from the font memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_fg_cand_ff  <= fg_cand;
      s2_gy_ff       <= s1_gy_ff;
      s2_last_col_ff <= s1_last_col_ff;
      s2_box_end_ff  <= s1_box_end_ff;
   end

   always_comb begin
      push_item.color   = (s2_fg_cand_ff && font_rd_data[s2_gy_ff]) ? fg_color_ff : bg_color_ff;
      push_item.row_end = s2_last_col_ff;
      push_item.box_end = s2_box_end_ff;
   end

   tbgr_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_item (push_item),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (rsp_item),
      .level     (fifo_level)
   );

`ifndef SYNTHESIS
   a_box_wrap: assert property (@(posedge clock) disable iff (reset)
      (is_pixel && last_col && last_row) |=> ((row_ff == 8'd0) && (col_ff == 8'd0)))
      else $error("Counters did not wrap after the last pixel of the box.");

   a_cpos_bound: assert property (@(posedge clock) disable iff (reset)
      cpos_ff <= CPOS_W'(TEXT_LEN))
      else $error("Character position ran past the end of the text.");

   a_credit: assert property (@(posedge clock) disable iff (reset)
      (int'(fifo_level) + int'(s1_valid_ff) + int'(s2_valid_ff)) <= OUT_DEPTH)
      else $error("More pixels in flight than the result queue can hold.");
`endif

endmodule

// File: tb/text_box_glyph_rasterizer_tb.sv
`timescale 1ns / 1ps

module text_box_glyph_rasterizer_tb;
   import tbgr_pkg::*;

   localparam int FONT_DEPTH = (LAST_CODE_DEF - FIRST_CODE_DEF + 1) * GLYPH_BYTES;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 380;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Shadow copy of the block's registers, stores and raster counters.
   logic [7:0] cfg_box_w = 8'd0;
   logic [7:0] cfg_box_h = 8'd0;
   logic [7:0] cfg_text_x = 8'd0;
   logic [7:0] cfg_text_y = 8'd0;
   logic [15:0] cfg_fg = FG_COLOR_RESET;
   logic [15:0] cfg_bg = BG_COLOR_RESET;
   logic [7:0] text_mem [TEXT_LEN_DEF];
   logic [7:0] font_mem [FONT_DEPTH];
   logic [7:0] row_cnt = 8'd0;
   logic [7:0] col_cnt = 8'd0;
   int char_pos = 0;
   int glyph_col = 0;
   logic text_done = 1'b0;

   rsp_type pending_pixels [$];
   int errors = 0;
   int cycle_count = 0;
   int stall_tick = 0;
   int burst_left = 0;
   int random_work = 0;

   text_box_glyph_rasterizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] next_text_pixel(input logic [7:0] gy);
      int code;
      int addr;
      logic [15:0] color;
      color = cfg_bg;
      if (char_pos >= TEXT_LEN_DEF) begin
         text_done = 1'b1;
      end else if (text_mem[char_pos] == 8'h00) begin
         text_done = 1'b1;
      end
      if (text_done) begin
         return cfg_bg;
      end
      code = text_mem[char_pos];
      if (code < FIRST_CODE_DEF || code > LAST_CODE_DEF) begin
         code = FALLBACK_CODE;
      end
      if (glyph_col < GLYPH_BYTES) begin
         addr = (code - FIRST_CODE_DEF) * GLYPH_BYTES + glyph_col;
         if (font_mem[addr][gy[2:0]]) begin
            color = cfg_fg;
         end
      end
      glyph_col++;
      if (glyph_col >= GLYPH_W_DEF) begin
         glyph_col = 0;
         char_pos++;
      end
      return color;
   endfunction

   function automatic void rasterize_item(input req_type it);
      logic [7:0] gy;
      logic [15:0] color;
      logic last_col;
      logic last_row;
      rsp_type px;
      case (it.func)
         FUNC_TEXT: begin
            if (it.index < TEXT_LEN_DEF) begin
               text_mem[it.index] = it.data;
            end
         end
         FUNC_FONT: begin
            if (it.index < FONT_DEPTH) begin
               font_mem[it.index] = it.data;
            end
         end
         FUNC_PIXEL: begin
            if (cfg_box_w != 8'd0 && cfg_box_h != 8'd0) begin
               gy = row_cnt - cfg_text_y;
               if (gy < GLYPH_H_DEF && col_cnt >= cfg_text_x) begin
                  color = next_text_pixel(gy);
               end else begin
                  color = cfg_bg;
               end
               last_col = col_cnt >= cfg_box_w - 8'd1;
               last_row = row_cnt >= cfg_box_h - 8'd1;
               px.color = color;
               px.row_end = last_col;
               px.box_end = last_col && last_row;
               pending_pixels.push_back(px);
               if (last_col) begin
                  col_cnt = 8'd0;
                  char_pos = 0;
                  glyph_col = 0;
                  text_done = 1'b0;
                  row_cnt = last_row ? 8'd0 : row_cnt + 8'd1;
               end else begin
                  col_cnt = col_cnt + 8'd1;
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected pixel", rsp_item.color, 16'h0000);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_item.color !== want.color) begin
               report_mismatch("color", rsp_item.color, want.color);
            end
            if (rsp_item.row_end !== want.row_end) begin
               report_mismatch("row_end", 16'(rsp_item.row_end), 16'(want.row_end));
            end
            if (rsp_item.box_end !== want.box_end) begin
               report_mismatch("box_end", 16'(rsp_item.box_end), 16'(want.box_end));
            end
         end
      end
      stall_tick++;
      case ((stall_tick / 256) % 4)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_tick % 8) < 5;
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] func, input logic [8:0] index,
                            input logic [7:0] data);
      req_type it;
      int gap;
      it.func = func;
      it.index = index;
      it.data = data;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      rasterize_item(it);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BOX_W: cfg_box_w = value[7:0];
         CSR_BOX_H: cfg_box_h = value[7:0];
         CSR_TEXT_X: cfg_text_x = value[7:0];
         CSR_TEXT_Y: cfg_text_y = value[7:0];
         CSR_FG_COLOR: cfg_fg = value;
         CSR_BG_COLOR: cfg_bg = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_box(input logic [7:0] w, input logic [7:0] h, input logic [7:0] x,
                          input logic [7:0] y, input logic [15:0] fg, input logic [15:0] bg);
      wait_idle();
      write_csr(CSR_BOX_W, 16'(w));
      write_csr(CSR_BOX_H, 16'(h));
      write_csr(CSR_TEXT_X, 16'(x));
      write_csr(CSR_TEXT_Y, 16'(y));
      write_csr(CSR_FG_COLOR, fg);
      write_csr(CSR_BG_COLOR, bg);
   endtask

   function automatic logic [7:0] random_char();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'($urandom_range(0, 255));
         2: return 8'(FIRST_CODE_DEF);
         default: return 8'($urandom_range(FIRST_CODE_DEF + 1, LAST_CODE_DEF));
      endcase
   endfunction

   // Nothing here may be drawn, so the font is still unloaded.
   task automatic test_ignored_items();
      send_item(FUNC_PIXEL, 9'd0, 8'd0);
      send_item(FUNC_UNUSED, 9'h1FF, 8'hFF);
      send_item(FUNC_TEXT, 9'(TEXT_LEN_DEF), 8'h41);
      send_item(FUNC_TEXT, 9'h1FF, 8'h5A);
      send_item(FUNC_FONT, 9'(FONT_DEPTH), 8'hFF);
      send_item(FUNC_FONT, 9'h1FF, 8'h00);
      wait_idle();
      write_csr(CSR_BOX_W, 16'd4);
      send_item(FUNC_PIXEL, 9'd0, 8'd0);
      send_item(FUNC_PIXEL, 9'd0, 8'd0);
   endtask

   task automatic test_font_load();
      for (int i = 0; i < FONT_DEPTH; i++) begin
         send_item(FUNC_FONT, 9'(i), 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_glyph_codes();
      send_item(FUNC_TEXT, 9'd0, 8'(FIRST_CODE_DEF - 1));
      send_item(FUNC_TEXT, 9'd1, 8'hFF);
      send_item(FUNC_TEXT, 9'd2, 8'(LAST_CODE_DEF));
      send_item(FUNC_TEXT, 9'd3, 8'(FIRST_CODE_DEF));
      send_item(FUNC_TEXT, 9'd4, 8'h00);
      send_item(FUNC_TEXT, 9'd5, 8'h41);
      set_box(8'd30, 8'd1, 8'd0, 8'd0, 16'hFFFF, 16'h0000);
      repeat (30) send_item(FUNC_PIXEL, 9'd0, 8'd0);
   endtask

   task automatic test_box_extremes();
      set_box(8'd255, 8'd255, 8'd255, 8'd255, 16'h0000, 16'hFFFF);
      repeat (6) send_item(FUNC_PIXEL, 9'd0, 8'd0);
      // Shrinking the box mid-row leaves the counters beyond its edges.
      set_box(8'd1, 8'd1, 8'd0, 8'd0, 16'h0000, 16'hFFFF);
      repeat (2) send_item(FUNC_PIXEL, 9'd0, 8'd0);
      set_box(8'd12, 8'd2, 8'd0, 8'd255, 16'hFFFF, 16'h0000);
      repeat (24) send_item(FUNC_PIXEL, 9'd0, 8'd0);
   endtask

   task automatic random_box();
      logic [7:0] w;
      logic [7:0] h;
      logic [7:0] x;
      logic [7:0] y;
      logic [15:0] fg;
      logic [15:0] bg;
      w = 8'($urandom_range(1, 40));
      h = 8'($urandom_range(1, 12));
      x = 8'($urandom_range(0, 24));
      y = 8'($urandom_range(0, 6));
      fg = 16'($urandom);
      bg = 16'($urandom);
      case ($urandom_range(0, 11))
         0: w = 8'd0;
         1: h = 8'd0;
         2: w = 8'd255;
         3: h = 8'd255;
         4: x = 8'd255;
         5: y = 8'($urandom_range(248, 255));
         6: begin
            fg = 16'hFFFF;
            bg = 16'h0000;
         end
         7: begin
            w = 8'd1;
            h = 8'd1;
         end
         default: ;
      endcase
      set_box(w, h, x, y, fg, bg);
   endtask

   task automatic random_items(input int count);
      int pick;
      logic [8:0] idx;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            send_item(FUNC_PIXEL, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
            if (cfg_box_w != 8'd0 && cfg_box_h != 8'd0) begin
               random_work++;
            end
         end else if (pick < 88) begin
            idx = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(TEXT_LEN_DEF, 511))
                                              : 9'($urandom_range(0, TEXT_LEN_DEF - 1));
            send_item(FUNC_TEXT, idx, random_char());
            if (idx < TEXT_LEN_DEF) begin
               random_work++;
            end
         end else if (pick < 97) begin
            idx = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(FONT_DEPTH, 511))
                                              : 9'($urandom_range(0, FONT_DEPTH - 1));
            send_item(FUNC_FONT, idx, 8'($urandom_range(0, 255)));
            if (idx < FONT_DEPTH) begin
               random_work++;
            end
         end else begin
            send_item(FUNC_UNUSED, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic test_random_text();
      for (int i = 0; i < TEXT_LEN_DEF; i++) begin
         send_item(FUNC_TEXT, 9'(i), 8'($urandom_range(FIRST_CODE_DEF, LAST_CODE_DEF)));
      end
      while (random_work < RANDOM_ITEMS) begin
         random_box();
         random_items($urandom_range(20, 120));
      end
   endtask

   initial begin
      for (int i = 0; i < TEXT_LEN_DEF; i++) begin
         text_mem[i] = 8'h00;
      end
      for (int i = 0; i < FONT_DEPTH; i++) begin
         font_mem[i] = 8'h00;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_ignored_items();
      test_font_load();
      test_glyph_codes();
      test_box_extremes();
      test_random_text();
      wait_idle();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/tbgr_pkg.sv
rtl/tbgr_text_mem.sv
rtl/tbgr_font_mem.sv
rtl/tbgr_out_fifo.sv
rtl/text_box_glyph_rasterizer.sv
tb/text_box_glyph_rasterizer_tb.sv
